>>> sv/circle_octant_ray_fan_raster_defines.svh
// Assertion macros shared by the fan rasterizer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef CIRCLE_OCTANT_RAY_FAN_RASTER_DEFINES_SVH
`define CIRCLE_OCTANT_RAY_FAN_RASTER_DEFINES_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define COFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fan raster assertion failed");

// Next-cycle implication checked at every rising clock edge outside reset.
`define COFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fan raster assertion failed");

`endif

>>> sv/cofr_pkg.sv
// Shared types and constants of the circle octant ray fan rasterizer.
// Depends on nothing; used by every module of the block.
package cofr_pkg;

	localparam int CENTER_BITS    = 11;
	localparam int RADIUS_BITS    = 10;
	localparam int COLOR_BITS     = 24;
	localparam int PIX_BITS       = 12;
	localparam int ARC_BITS       = 12;
	localparam int DEC_BITS       = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 24;
	localparam int IN_DATA_BITS   = 24;
	localparam int OUT_DATA_BITS  = 48;

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 10'd200;
	localparam logic [COLOR_BITS-1:0]  COLOR_RESET  = 24'hFF2D00;

	localparam int DEC_INIT   = 3;
	localparam int DEC_STEP_A = 6;
	localparam int DEC_STEP_B = 10;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_RADIUS = 2'd0,
		REG_COLOR  = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_TICK  = 1'b1
	} command_t;

	typedef struct packed {
		logic                  last_pixel;
		logic [COLOR_BITS-1:0] color;
		logic [PIX_BITS-1:0]   pixel_y;
		logic [PIX_BITS-1:0]   pixel_x;
	} pixel_t;

	typedef struct packed {
		logic busy;
		logic ray_end;
	} core_stat_t;

endpackage

>>> sv/circle_octant_ray_fan_raster.sv
// Top level of the circle octant ray fan rasterizer: configuration registers and stream ports.
// Depends on cofr_pkg, cofr_fan_core, cofr_out_buf and the assertion macro header.
//
// A start transaction (tuser low) latches the center and sets up a new fan; it gives no
// output. Each tick transaction (tuser high) while a fan runs gives one pixel, walking
// the rays from the center to the points of one octant of the circle, and the final
// pixel carries tlast. Ticks while no fan runs give nothing. The block takes one
// transaction every cycle while the pixel stream is ready: the whole step of the circle
// and line state is computed combinationally from the state registers. An output register
// with one skid entry absorbs the pixel of one tick while the pixel stream stalls; after
// that s_axis_tready stays low until the stream takes a pixel. A pixel appears on the
// output the cycle after its tick is taken when the output register is free, and later
// while the stream stalls. Configuration writes are taken in any cycle.
`include "circle_octant_ray_fan_raster_defines.svh"

module circle_octant_ray_fan_raster #(
	parameter int COORD_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [cofr_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,  // center_x, center_y
	input  logic                                   s_axis_tuser,  // command
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [cofr_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,  // pixel_x, pixel_y, color
	output logic                                   m_axis_tlast,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [cofr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [cofr_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import cofr_pkg::*;

	logic [RADIUS_BITS-1:0] radius_q;
	logic [COLOR_BITS-1:0]  color_q;
	logic                   in_accept;
	logic                   start_accept;
	logic                   res_valid;
	pixel_t                 res;
	pixel_t                 out_pix;
	core_stat_t             core_stat;
	logic                   buf_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			color_q  <= COLOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_RADIUS: radius_q <= cfg_data[RADIUS_BITS-1:0];
				REG_COLOR:  color_q  <= cfg_data[COLOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !buf_full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign start_accept  = in_accept && (command_t'(s_axis_tuser) == CMD_START);

	cofr_fan_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (in_accept),
		.in_cmd     (command_t'(s_axis_tuser)),
		.center_x   ($signed(s_axis_tdata[CENTER_BITS-1:0])),
		.center_y   ($signed(s_axis_tdata[2*CENTER_BITS-1:CENTER_BITS])),
		.radius     (radius_q),
		.pixel_color(color_q),
		.res_valid  (res_valid),
		.res        (res),
		.stat       (core_stat)
	);

	cofr_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.full     (buf_full),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (out_pix)
	);

	assign m_axis_tdata = {out_pix.color, out_pix.pixel_y, out_pix.pixel_x};
	assign m_axis_tlast = out_pix.last_pixel;

	`COFR_ASSERT_IMPLIES(a_full_has_output, clk, arst_n, !s_axis_tready, m_axis_tvalid)
	`COFR_ASSERT_NEXT(a_start_arms_fan, clk, arst_n, start_accept, core_stat.busy)
	`COFR_ASSERT_NEXT(a_last_ends_fan, clk, arst_n, res_valid && res.last_pixel, !core_stat.busy)
	`COFR_ASSERT_IMPLIES(a_last_at_ray_end, clk, arst_n, res_valid && res.last_pixel, core_stat.ray_end)
	`COFR_ASSERT_IMPLIES(a_pixel_needs_fan, clk, arst_n, res_valid, core_stat.busy)

endmodule

>>> sv/cofr_ray_setup.sv
// Ray setup: endpoint, spans, directions and initial error of one Bresenham ray.
// Depends on cofr_pkg for field widths.
module cofr_ray_setup #(
	parameter int COORD_BITS = 12
) (
	input  logic signed [cofr_pkg::CENTER_BITS-1:0] origin_x,
	input  logic signed [cofr_pkg::CENTER_BITS-1:0] origin_y,
	input  logic signed [cofr_pkg::ARC_BITS-1:0]    arc_x,
	input  logic signed [cofr_pkg::ARC_BITS-1:0]    arc_y,
	output logic signed [COORD_BITS-1:0]            walk_x,
	output logic signed [COORD_BITS-1:0]            walk_y,
	output logic signed [COORD_BITS-1:0]            target_x,
	output logic signed [COORD_BITS-1:0]            target_y,
	output logic        [COORD_BITS-1:0]            span_x,
	output logic        [COORD_BITS-1:0]            span_y,
	output logic                                    dir_x,
	output logic                                    dir_y,
	output logic signed [COORD_BITS:0]              walk_error
);
	import cofr_pkg::*;

	localparam int SUM_BITS = ARC_BITS + 1;

	logic signed [SUM_BITS-1:0]   end_x;
	logic signed [SUM_BITS-1:0]   end_y;
	logic signed [COORD_BITS:0]   diff_x;
	logic signed [COORD_BITS:0]   diff_y;
	logic signed [COORD_BITS:0]   abs_x;
	logic signed [COORD_BITS:0]   abs_y;

	always_comb begin
		end_x    = SUM_BITS'(origin_x) + SUM_BITS'(arc_y);
		end_y    = SUM_BITS'(origin_y) - SUM_BITS'(arc_x);
		walk_x   = COORD_BITS'(origin_x);
		walk_y   = COORD_BITS'(origin_y);
		target_x = COORD_BITS'(end_x);
		target_y = COORD_BITS'(end_y);
		diff_x   = (COORD_BITS+1)'(target_x) - (COORD_BITS+1)'(walk_x);
		diff_y   = (COORD_BITS+1)'(target_y) - (COORD_BITS+1)'(walk_y);
		abs_x    = diff_x[COORD_BITS] ? -diff_x : diff_x;
		abs_y    = diff_y[COORD_BITS] ? -diff_y : diff_y;
		span_x   = abs_x[COORD_BITS-1:0];
		span_y   = abs_y[COORD_BITS-1:0];
		dir_x    = walk_x < target_x;
		dir_y    = walk_y < target_y;
		walk_error = $signed({1'b0, span_x}) - $signed({1'b0, span_y});
	end

endmodule

>>> sv/cofr_fan_core.sv
// Fan state and combinational step logic: midpoint circle over rays, Bresenham walk per ray.
// Depends on cofr_pkg and cofr_ray_setup.
module cofr_fan_core #(
	parameter int COORD_BITS = 12
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_accept,
	input  cofr_pkg::command_t                      in_cmd,
	input  logic signed [cofr_pkg::CENTER_BITS-1:0] center_x,
	input  logic signed [cofr_pkg::CENTER_BITS-1:0] center_y,
	input  logic        [cofr_pkg::RADIUS_BITS-1:0] radius,
	input  logic        [cofr_pkg::COLOR_BITS-1:0]  pixel_color,
	output logic                                    res_valid,
	output cofr_pkg::pixel_t                        res,
	output cofr_pkg::core_stat_t                    stat
);
	import cofr_pkg::*;

	logic                          busy_q;
	logic signed [CENTER_BITS-1:0] origin_x_q, origin_y_q;
	logic signed [ARC_BITS-1:0]    arc_x_q, arc_y_q;
	logic signed [DEC_BITS-1:0]    decision_q;
	logic signed [COORD_BITS-1:0]  walk_x_q, walk_y_q, target_x_q, target_y_q;
	logic        [COORD_BITS-1:0]  span_x_q, span_y_q;
	logic                          dir_x_q, dir_y_q;
	logic signed [COORD_BITS:0]    err_q;

	logic                          is_start;
	logic                          tick_live;
	logic                          at_target;
	logic                          fan_more;
	logic signed [ARC_BITS-1:0]    arc_x_n, arc_y_n;
	logic signed [DEC_BITS-1:0]    dec_n, dec_init;
	logic signed [CENTER_BITS-1:0] set_org_x, set_org_y;
	logic signed [ARC_BITS-1:0]    set_arc_x, set_arc_y;
	logic signed [COORD_BITS-1:0]  rs_walk_x, rs_walk_y, rs_target_x, rs_target_y;
	logic        [COORD_BITS-1:0]  rs_span_x, rs_span_y;
	logic                          rs_dir_x, rs_dir_y;
	logic signed [COORD_BITS:0]    rs_err;
	logic signed [COORD_BITS+1:0]  e2;
	logic                          step_x, step_y;
	logic signed [COORD_BITS:0]    err_n;

	always_comb begin
		is_start  = in_cmd == CMD_START;
		tick_live = in_accept && !is_start && busy_q;
		at_target = (walk_x_q == target_x_q) && (walk_y_q == target_y_q);
		arc_x_n   = arc_x_q + ARC_BITS'(1);
		if (decision_q[DEC_BITS-1]) begin
			arc_y_n = arc_y_q;
			dec_n   = decision_q + (DEC_BITS'(arc_x_q) <<< 2) + DEC_BITS'(DEC_STEP_A);
		end else begin
			arc_y_n = arc_y_q - ARC_BITS'(1);
			dec_n   = decision_q + (DEC_BITS'(arc_x_q - arc_y_q) <<< 2)
				+ DEC_BITS'(DEC_STEP_B);
		end
		fan_more = arc_x_n <= arc_y_n;
		dec_init = DEC_BITS'(DEC_INIT) - $signed({DEC_BITS'(radius)} << 1);

		set_org_x = is_start ? center_x : origin_x_q;
		set_org_y = is_start ? center_y : origin_y_q;
		set_arc_x = is_start ? '0 : arc_x_n;
		set_arc_y = is_start ? $signed(ARC_BITS'(radius)) : arc_y_n;

		e2     = {err_q, 1'b0};
		step_x = e2 > -$signed({2'b00, span_y_q});
		step_y = e2 < $signed({2'b00, span_x_q});
		err_n  = err_q - (step_x ? $signed({1'b0, span_y_q}) : '0)
			+ (step_y ? $signed({1'b0, span_x_q}) : '0);

		res_valid      = tick_live;
		res.pixel_x    = PIX_BITS'($unsigned(walk_x_q));
		res.pixel_y    = PIX_BITS'($unsigned(walk_y_q));
		res.color      = pixel_color;
		res.last_pixel = at_target && !fan_more;

		stat.busy    = busy_q;
		stat.ray_end = busy_q && at_target;
	end

	cofr_ray_setup #(
		.COORD_BITS(COORD_BITS)
	) u_ray_setup (
		.origin_x  (set_org_x),
		.origin_y  (set_org_y),
		.arc_x     (set_arc_x),
		.arc_y     (set_arc_y),
		.walk_x    (rs_walk_x),
		.walk_y    (rs_walk_y),
		.target_x  (rs_target_x),
		.target_y  (rs_target_y),
		.span_x    (rs_span_x),
		.span_y    (rs_span_y),
		.dir_x     (rs_dir_x),
		.dir_y     (rs_dir_y),
		.walk_error(rs_err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			arc_x_q    <= '0;
			arc_y_q    <= '0;
			decision_q <= '0;
			walk_x_q   <= '0;
			walk_y_q   <= '0;
			target_x_q <= '0;
			target_y_q <= '0;
			span_x_q   <= '0;
			span_y_q   <= '0;
			dir_x_q    <= 1'b0;
			dir_y_q    <= 1'b0;
			err_q      <= '0;
		end else if (in_accept) begin
			if (is_start || (busy_q && at_target && fan_more)) begin
				walk_x_q   <= rs_walk_x;
				walk_y_q   <= rs_walk_y;
				target_x_q <= rs_target_x;
				target_y_q <= rs_target_y;
				span_x_q   <= rs_span_x;
				span_y_q   <= rs_span_y;
				dir_x_q    <= rs_dir_x;
				dir_y_q    <= rs_dir_y;
				err_q      <= rs_err;
			end
			if (is_start) begin
				busy_q     <= 1'b1;
				origin_x_q <= center_x;
				origin_y_q <= center_y;
				arc_x_q    <= '0;
				arc_y_q    <= $signed(ARC_BITS'(radius));
				decision_q <= dec_init;
			end else if (busy_q) begin
				if (at_target) begin
					decision_q <= dec_n;
					arc_x_q    <= arc_x_n;
					arc_y_q    <= arc_y_n;
					busy_q     <= fan_more;
				end else begin
					err_q <= err_n;
					if (step_x) begin
						walk_x_q <= dir_x_q ? walk_x_q + COORD_BITS'(1)
							: walk_x_q - COORD_BITS'(1);
					end
					if (step_y) begin
						walk_y_q <= dir_y_q ? walk_y_q + COORD_BITS'(1)
							: walk_y_q - COORD_BITS'(1);
					end
				end
			end
		end
	end

endmodule

>>> sv/cofr_out_buf.sv
// Output register with one skid entry between the fan core and the pixel stream.
// Depends on cofr_pkg for the pixel type.
module cofr_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cofr_pkg::pixel_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_ready,
	output cofr_pkg::pixel_t out_data
);
	import cofr_pkg::*;

	logic   out_valid_q;
	logic   skid_valid_q;
	pixel_t out_data_q;
	pixel_t skid_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
